// File: design/emsp_pkg.sv
// Package for the encoder median speed PID unit: widths, register indexes,
// speed constants and shared cell types. No dependencies.
package emsp_pkg;
	localparam int Window = 15;
	localparam int SlotW = $clog2(Window);
	localparam int PerW = 32;
	localparam int SpeedW = 12;
	localparam logic [SpeedW-1:0] SpeedMax = 12'd4095;
	localparam logic [31:0] SpeedNum = 32'd25500000;
	localparam logic [7:0] SpeedDen = 8'd141;

	typedef enum logic [2:0] {
		REG_SETPOINT = 3'd0,
		REG_GAIN_P   = 3'd1,
		REG_GAIN_I   = 3'd2,
		REG_GAIN_D   = 3'd3,
		REG_ILIMIT   = 3'd4,
		REG_TIMEOUT  = 3'd5
	} reg_idx_t;

	// Token handed along the chain of rank cells during a median sweep.
	typedef struct packed {
		logic            vld;
		logic [PerW-1:0] val;
		logic [4:0]      idx;
	} rank_tok_t;
endpackage

// File: design/emsp_rank_cell.sv
// One cell of the median chain: holds one ring entry and counts how many
// entries rank below it as the tokens of all entries pass by. Uses emsp_pkg.
module emsp_rank_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  logic [emsp_pkg::PerW-1:0] wr_val,
	input  logic                  clr,
	input  logic [4:0]            my_idx,
	input  emsp_pkg::rank_tok_t   tok_in,
	output emsp_pkg::rank_tok_t   tok_out,
	output logic [emsp_pkg::PerW-1:0] val,
	output logic [4:0]            rank
);
	import emsp_pkg::*;
	logic [PerW-1:0] val_q;
	logic [4:0] rank_q;
	logic below;

	// Ties are broken by index so ranks form a permutation.
	assign below = tok_in.vld && ((tok_in.val < val_q) ||
		(tok_in.val == val_q && tok_in.idx < my_idx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			rank_q <= '0;
			tok_out <= '0;
		end else begin
			if (wr) val_q <= wr_val;
			if (clr) rank_q <= '0;
			else if (below) rank_q <= rank_q + 5'd1;
			tok_out <= tok_in;
		end
	end
	assign val = val_q;
	assign rank = rank_q;
endmodule

// File: design/emsp_divider.sv
// Restoring divider, one quotient bit per cycle, for the speed quotient.
// Uses emsp_pkg.
module emsp_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [39:0] den,
	output logic        done,
	output logic [31:0] quo
);
	import emsp_pkg::*;
	logic [39:0] rem_q;
	logic [31:0] quo_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [40:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
				rem_q <= '0;
				quo_q <= num;
			end else if (busy_q) begin
				if (!trial[40]) begin
					rem_q <= trial[39:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[38:0], quo_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	assign quo = quo_q;
endmodule

// File: design/encoder_median_speed_pid_unit.sv
// Top level of the encoder median speed PID unit: ring of rank cells,
// speed divider and a sequenced PID step. Uses emsp_pkg, emsp_rank_cell,
// emsp_divider.
//
// Channel   Signals                                         Dir
// input     in_valid in_ready op cycle_time chan_b usec_now  in
// output    out_valid out_ready drive_level direction        out
//           measured_speed
// config    cfg_we cfg_index cfg_data                       in
//
// An edge word never leaves S_IDLE, so edge words can follow back to back.
// A tick word runs through the accept, a sweep that passes every entry's
// token along the rank chain, a pick of the median, the divider, then 5 PID
// steps with the P, I and D terms on one shared multiplier. One tick at a time.
// Reset clears the ring, the PID state and loads register defaults.
// A result waits in the output register; edge words are still taken then,
// but a new tick waits until the result has left.
module encoder_median_speed_pid_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [63:0] cycle_time,
	input  logic        chan_b,
	input  logic [31:0] usec_now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  drive_level,
	output logic        direction,
	output logic [11:0] measured_speed,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import emsp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SWEEP, S_PICK, S_DIV, S_ERR, S_MP, S_MI, S_MD, S_OUT
	} state_t;

	state_t state_q;
	logic [7:0] setpoint_q;
	logic [15:0] gain_p_q, gain_i_q, gain_d_q, timeout_q;
	logic [12:0] ilimit_q;
	logic [SlotW-1:0] slot_q;
	logic [63:0] last_cyc_q;
	logic [31:0] last_us_q, usec_q;
	logic dir_q;
	logic signed [13:0] esum_q;
	logic signed [12:0] perr_q, e_q;
	logic signed [13:0] d_q;
	logic [5:0] step_q;
	logic [SpeedW-1:0] speed_q;
	logic [PerW-1:0] med_q;
	logic signed [47:0] acc_q;
	logic out_valid_q;
	logic [7:0] drive_q;
	logic [SpeedW-1:0] ospeed_q;
	logic odir_q;

	// Rank chain: tokens enter cell 0 and walk to the last cell.
	rank_tok_t tok [Window+1];
	rank_tok_t tok_src;
	logic [PerW-1:0] cval [Window];
	logic [4:0] crank [Window];
	logic [Window-1:0] cwr;
	logic sweep_clr;
	logic [PerW-1:0] period_new;

	assign period_new = 32'(cycle_time - last_cyc_q);
	assign sweep_clr = (state_q == S_IDLE);
	assign tok[0] = tok_src;

	genvar g;
	generate
		for (g = 0; g < Window; g++) begin : g_cell
			assign cwr[g] = in_valid && in_ready && !op && (slot_q == SlotW'(g));
			emsp_rank_cell u_cell (
				.clk(clk), .arst_n(arst_n), .wr(cwr[g]), .wr_val(period_new),
				.clr(sweep_clr), .my_idx(5'(g)), .tok_in(tok[g]),
				.tok_out(tok[g+1]), .val(cval[g]), .rank(crank[g])
			);
		end
	endgenerate

	// Token source: feeds entry step_q during the sweep while step_q is below Window.
	always_comb begin
		tok_src = '0;
		if (state_q == S_SWEEP && step_q < 6'(Window)) begin
			tok_src.vld = 1'b1;
			tok_src.val = cval[step_q[SlotW-1:0]];
			tok_src.idx = 5'(step_q);
		end
	end

	// Median select: the entry whose rank is Window/2.
	logic [PerW-1:0] med_sel;
	always_comb begin
		med_sel = '0;
		for (int k = 0; k < Window; k++)
			if (crank[k] == 5'(Window / 2)) med_sel = cval[k];
	end

	// Divider for speed = 25500000 / (141 * median).
	logic div_start, div_done;
	logic [31:0] div_quo;
	logic [39:0] den;
	assign den = 40'(med_q) * 40'(SpeedDen);
	emsp_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(SpeedNum),
		.den(den), .done(div_done), .quo(div_quo)
	);
	// The median is loaded into med_q at the same edge that starts the divider.
	assign div_start = (state_q == S_PICK) && (med_sel != '0);

	// Shared multiplier for the PID terms.
	logic signed [16:0] mul_a;
	logic signed [13:0] mul_b;
	logic signed [31:0] mul_p;
	always_comb begin
		unique case (state_q)
			S_MP: begin mul_a = $signed({1'b0, gain_p_q}); mul_b = 14'(e_q); end
			S_MI: begin mul_a = $signed({1'b0, gain_i_q}); mul_b = esum_q; end
			default: begin mul_a = $signed({1'b0, gain_d_q}); mul_b = d_q; end
		endcase
	end
	assign mul_p = 32'(mul_a * mul_b);

	// Error, integral and drive arithmetic.
	logic signed [13:0] e_new;
	logic signed [14:0] sum_raw, lim_s;
	logic signed [13:0] sum_clamped;
	logic signed [47:0] corr;
	logic signed [48:0] drv;
	assign e_new = $signed({2'b0, speed_q}) - $signed({6'b0, setpoint_q});
	assign lim_s = $signed({2'b0, ilimit_q});
	assign sum_raw = 15'(esum_q) + 15'(e_new);
	always_comb begin
		if (sum_raw > lim_s) sum_clamped = 14'(lim_s);
		else if (sum_raw < -lim_s) sum_clamped = 14'(-lim_s);
		else sum_clamped = 14'(sum_raw);
	end
	assign corr = (acc_q < 0) ? -((-acc_q) >>> 12) : (acc_q >>> 12);
	assign drv = $signed({41'b0, setpoint_q}) - 49'(corr);

	assign in_ready = (state_q == S_IDLE) && !(out_valid_q && !out_ready &&
		in_valid && op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			setpoint_q <= 8'd50;
			gain_p_q <= 16'd16384;
			gain_i_q <= 16'd410;
			gain_d_q <= 16'd0;
			ilimit_q <= 13'd5000;
			timeout_q <= 16'd6667;
			slot_q <= '0;
			last_cyc_q <= '0;
			last_us_q <= '0;
			dir_q <= 1'b0;
			esum_q <= '0;
			perr_q <= '0;
			e_q <= '0;
			d_q <= '0;
			step_q <= '0;
			speed_q <= '0;
			med_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
			drive_q <= '0;
			ospeed_q <= '0;
			odir_q <= 1'b0;
			usec_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SETPOINT: setpoint_q <= cfg_data[7:0];
					REG_GAIN_P:   gain_p_q <= cfg_data;
					REG_GAIN_I:   gain_i_q <= cfg_data;
					REG_GAIN_D:   gain_d_q <= cfg_data;
					REG_ILIMIT:   ilimit_q <= cfg_data[12:0];
					REG_TIMEOUT:  timeout_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					if (!op) begin
						dir_q <= chan_b;
						last_cyc_q <= cycle_time;
						last_us_q <= usec_now;
						slot_q <= (slot_q == SlotW'(Window - 1)) ? '0 : slot_q + 1'b1;
					end else begin
						usec_q <= usec_now;
						step_q <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'(2 * Window)) state_q <= S_PICK;
				end
				S_PICK: begin
					med_q <= med_sel;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (32'(usec_q - last_us_q) > {16'b0, timeout_q}) begin
						speed_q <= '0;
						state_q <= S_ERR;
					end else if (med_q == '0) begin
						speed_q <= SpeedMax;
						state_q <= S_ERR;
					end else if (div_done) begin
						speed_q <= (div_quo > 32'(SpeedMax)) ? SpeedMax : div_quo[11:0];
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					e_q <= 13'(e_new);
					d_q <= e_new - 14'(perr_q);
					perr_q <= 13'(e_new);
					esum_q <= sum_clamped;
					acc_q <= '0;
					state_q <= S_MP;
				end
				S_MP: begin acc_q <= acc_q + 48'(mul_p); state_q <= S_MI; end
				S_MI: begin acc_q <= acc_q + 48'(mul_p); state_q <= S_MD; end
				S_MD: begin acc_q <= acc_q + 48'(mul_p); state_q <= S_OUT; end
				S_OUT: if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
					drive_q <= (drv < 0) ? 8'd0 : ((drv > 49'sd255) ? 8'd255 : drv[7:0]);
					ospeed_q <= speed_q;
					odir_q <= dir_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign drive_level = drive_q;
	assign direction = odir_q;
	assign measured_speed = ospeed_q;

	// The integral never leaves its clamp.
	a_esum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MP |-> (esum_q <= lim_s && esum_q >= -lim_s))
		else $error("integral outside limit");
	// A result is held while the consumer stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_level))
		else $error("result dropped");
	// No word is taken while a tick is in progress.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("accept while busy");
endmodule

// File: verif/encoder_median_speed_pid_unit_tb.sv
// Testbench for the encoder median speed PID unit: directed and random edge and
// tick words, with a local speed and PID predictor and an in-order result check.
// Depends on emsp_pkg and encoder_median_speed_pid_unit.
module encoder_median_speed_pid_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import emsp_pkg::*;

	localparam int Slots = 15;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = 1'b0;
	logic [63:0] cycle_time = '0;
	logic        chan_b = 1'b0;
	logic [31:0] usec_now = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  drive_level;
	logic        direction;
	logic [11:0] measured_speed;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	encoder_median_speed_pid_unit dut (.*);

	always #6 clk = ~clk;

	typedef struct packed {
		logic [7:0]  drive;
		logic        dir;
		logic [11:0] speed;
	} drive_word_t;

	// Predictor state and register copies.
	logic [7:0]  set_pt;
	logic [15:0] kp, ki, kd, tmo;
	logic [12:0] ilim;
	logic [31:0] ring [Slots];
	int          slot;
	logic [63:0] last_cyc;
	logic [31:0] last_us;
	logic        dir_q;
	int          err_sum, err_prev;

	drive_word_t pending_drive[$];
	int          fails = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_off = 0;
	logic [63:0] cyc_now;
	logic [31:0] us_now;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	function automatic logic [11:0] speed_from_median();
		logic [31:0] s [Slots];
		logic [31:0] v;
		logic [63:0] q;
		int j;
		for (int i = 0; i < Slots; i++) s[i] = ring[i];
		for (int i = 1; i < Slots; i++) begin
			v = s[i];
			j = i - 1;
			while (j >= 0 && s[j] > v) begin
				s[j+1] = s[j];
				j--;
			end
			s[j+1] = v;
		end
		v = s[Slots/2];
		if (v == 0) return 12'd4095;
		q = 64'd25500000 / (64'd141 * 64'(v));
		return (q > 4095) ? 12'd4095 : q[11:0];
	endfunction

	// Update the model for one word; a tick queues the expected drive word.
	task automatic predict_drive(input logic o, input logic [63:0] cyc, input logic cb,
			input logic [31:0] us);
		logic [31:0] dt;
		logic [11:0] spd;
		int e, d, lim;
		longint acc, corr, drv;
		drive_word_t w;
		if (o == 1'b0) begin
			dir_q = cb;
			dt = 32'(cyc - last_cyc);
			ring[slot] = dt;
			last_cyc = cyc;
			last_us = us;
			slot = (slot + 1) % Slots;
			return;
		end
		dt = us - last_us;
		spd = (dt > 32'(tmo)) ? 12'd0 : speed_from_median();
		e = int'(spd) - int'(set_pt);
		d = e - err_prev;
		lim = int'(ilim);
		err_sum += e;
		if (err_sum > lim) err_sum = lim;
		else if (err_sum < -lim) err_sum = -lim;
		acc = longint'(kp) * e + longint'(ki) * err_sum + longint'(kd) * d;
		corr = acc / 4096;
		err_prev = e;
		drv = longint'(set_pt) - corr;
		if (drv < 0) drv = 0;
		else if (drv > 255) drv = 255;
		w.drive = drv[7:0];
		w.dir = dir_q;
		w.speed = spd;
		pending_drive.push_back(w);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SETPOINT: set_pt = val[7:0];
			REG_GAIN_P:   kp = val;
			REG_GAIN_I:   ki = val;
			REG_GAIN_D:   kd = val;
			REG_ILIMIT:   ilim = val[12:0];
			REG_TIMEOUT:  tmo = val;
			default: ;
		endcase
	endtask

	// Send one word; valid stays high across back-to-back words.
	task automatic send_word(input logic o, input logic [63:0] cyc, input logic cb,
			input logic [31:0] us);
		while ($urandom_range(99) < send_idle_pct) begin
			if (in_valid) in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		cycle_time <= cyc;
		chan_b <= cb;
		usec_now <= us;
		predict_drive(o, cyc, cb, us);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
	endtask

	// Wait for every expected word, then let an edge word finish.
	task automatic drain();
		int n;
		stop_sending();
		n = 0;
		while (pending_drive.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (80) @(posedge clk);
	endtask

	task automatic edge_at(input int dcyc, input logic cb, input int dus);
		cyc_now += 64'(dcyc);
		us_now += 32'(dus);
		send_word(1'b0, cyc_now, cb, us_now);
	endtask

	task automatic tick_at(input int dus);
		us_now += 32'(dus);
		send_word(1'b1, 64'($urandom), 1'($urandom_range(1)), us_now);
	endtask

	// Receiver: ready idles at random or holds off for a counted stretch.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		drive_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_drive.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				w = pending_drive.pop_front();
				if (drive_level !== w.drive) report_mismatch("drive_level", drive_level, w.drive);
				if (direction !== w.dir) report_mismatch("direction", direction, w.dir);
				if (measured_speed !== w.speed)
					report_mismatch("measured_speed", measured_speed, w.speed);
			end
		end
	end

	// Ring as it stands (reset zeros on the first run), then full-scale fields, zero and
	// long periods, wrapping counters and the timeout boundary.
	task automatic test_directed();
		tick_at(0);
		edge_at(0, 1'b1, 5);
		tick_at(0);
		cyc_now = 64'hFFFF_FFFF_FFFF_FFF0;
		us_now = 32'hFFFF_FFF0;
		edge_at(0, 1'b0, 0);
		edge_at(32, 1'b1, 32);
		tick_at(int'(tmo));
		tick_at(1);
		for (int i = 0; i < 8; i++) edge_at(1000 + i, i[0], 3);
		tick_at(0);
		edge_at(-1, 1'b1, 1);
		for (int i = 0; i < 8; i++) edge_at(200000, 1'b0, 2);
		tick_at(5);
		send_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_word(1'b1, 64'h0, 1'b0, 32'h0);
		cyc_now = 64'hFFFF_FFFF_FFFF_FFFF;
		us_now = 32'hFFFF_FFFF;
		drain();
	endtask

	// Realistic edge trains with ticks mixed in, plus noise words.
	task automatic test_random(input int words);
		int per;
		per = $urandom_range(180, 60000);
		for (int i = 0; i < words; i++) begin
			case ($urandom_range(9))
				0: send_word(1'($urandom_range(1)), {$urandom, $urandom},
					1'($urandom_range(1)), $urandom);
				1, 2, 3: tick_at($urandom_range(int'(tmo) + 20));
				4: edge_at($urandom_range(3), 1'($urandom_range(1)), $urandom_range(3));
				default: edge_at(per + $urandom_range(per / 4), 1'($urandom_range(1)),
					$urandom_range(400));
			endcase
			if ($urandom_range(30) == 0) per = $urandom_range(100, 200000);
		end
		drain();
	endtask

	task automatic test_config(input logic [7:0] sp, input logic [15:0] p, input logic [15:0] i_g,
			input logic [15:0] d_g, input logic [12:0] lim, input logic [15:0] t);
		write_reg(REG_SETPOINT, {8'd0, sp});
		write_reg(REG_GAIN_P, p);
		write_reg(REG_GAIN_I, i_g);
		write_reg(REG_GAIN_D, d_g);
		write_reg(REG_ILIMIT, {3'd0, lim});
		write_reg(REG_TIMEOUT, t);
	endtask

	// Hold the receiver back while words keep coming, so the input stalls.
	task automatic test_backpressure();
		hold_off = 3000;
		for (int i = 0; i < 40; i++) tick_at($urandom_range(50));
		drain();
	endtask

	initial begin
		set_pt = 8'd50; kp = 16'd16384; ki = 16'd410; kd = 16'd0;
		ilim = 13'd5000; tmo = 16'd6667;
		for (int i = 0; i < Slots; i++) ring[i] = '0;
		slot = 0; last_cyc = '0; last_us = '0; dir_q = 1'b0;
		err_sum = 0; err_prev = 0;
		cyc_now = '0; us_now = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 33; recv_idle_pct = 85;
		test_directed();
		test_random(250);
		test_config(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13'h1FFF, 16'hFFFF);
		test_directed();
		send_idle_pct = 85; recv_idle_pct = 33;
		test_random(250);
		test_config(8'd0, 16'd0, 16'd0, 16'd0, 13'd0, 16'd0);
		test_random(100);
		test_config(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			13'($urandom), 16'($urandom_range(200, 8000)));
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(250);
		test_backpressure();

		if (fails == 0 && pending_drive.size() == 0) begin
			$display("encoder_median_speed_pid_unit test passed");
		end else begin
			$display("encoder_median_speed_pid_unit test failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("encoder_median_speed_pid_unit test failed");
		$finish;
	end
endmodule
